// ===== hw/rtl/mtep_pkg.sv =====
package mtep_pkg;

  // length counters and the front-to-back command queue
  localparam int LenBits = 28;
  localparam int CqDepth = 4;
  localparam int CqPtrW  = (CqDepth > 1) ? $clog2(CqDepth) : 1;
  localparam int CqCntW  = $clog2(CqDepth + 1);

  // byte codes
  localparam logic [7:0] ST_META  = 8'hFF;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_ESC   = 8'hF7;
  localparam logic [7:0] DATA_MSK = 8'h7F;

  // one parsed input byte: one or two result bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       e0;
    logic       s0;
    logic [7:0] b1;
    logic       e1;
  } mtep_cmd_t;

  // message length in bytes for a status byte
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd0;
    if (!s[7]) begin
      len = 2'd0;
    end else if (s < 8'hC0) begin
      len = 2'd3;
    end else if (s < 8'hE0) begin
      len = 2'd2;
    end else if (s < 8'hF0) begin
      len = 2'd3;
    end else begin
      unique case (s) inside
        8'hF1, 8'hF3: len = 2'd2;
        8'hF2: len = 2'd3;
        8'hF6, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE: len = 2'd1;
        default: len = 2'd0;
      endcase
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/midi_track_event_parser.sv =====
// channel  | ports                                 | handshake
// input    | in_data_byte, in_start_of_track       | push / full
// result   | out_byte, out_message_end,            | empty / pop
//          | out_from_sysex, out_run_last          |
//
// one track byte per cycle is taken unless full; it is classified in the cycle taken
// a byte with two results gives two output bytes; a 4-entry request queue absorbs that
// full = request queue full; each result passes the queue, then the output register
// reset is synchronous, active low, and clears parser state, queue and output valid
module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_track,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_message_end,
  output logic       out_from_sysex,
  output logic       out_run_last
);

  logic      take;
  logic      cq_push, cq_pop, cq_full, cq_empty;
  mtep_cmd_t cq_din, cq_dout;

  assign full = cq_full;
  assign take = push && !cq_full;

  // byte parser
  mtep_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .data_byte      (in_data_byte),
    .start_of_track (in_start_of_track),
    .cmd_push       (cq_push),
    .cmd            (cq_din)
  );

  // request queue between parser and output
  mtep_cmd_fifo u_cq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (cq_din),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .full  (cq_full),
    .empty (cq_empty)
  );

  // result expansion and output register
  mtep_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (cq_empty),
    .cmd             (cq_dout),
    .cmd_pop         (cq_pop),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_message_end (out_message_end),
    .out_from_sysex  (out_from_sysex),
    .out_run_last    (out_run_last)
  );

endmodule

// ===== hw/rtl/mtep_front.sv =====
module mtep_front
  import mtep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       start_of_track,
  output logic       cmd_push,
  output mtep_cmd_t  cmd
);

  localparam logic [2:0] PH_DELTA      = 3'd0;
  localparam logic [2:0] PH_STATUS     = 3'd1;
  localparam logic [2:0] PH_META_TYPE  = 3'd2;
  localparam logic [2:0] PH_META_LEN   = 3'd3;
  localparam logic [2:0] PH_META_SKIP  = 3'd4;
  localparam logic [2:0] PH_SYSEX_LEN  = 3'd5;
  localparam logic [2:0] PH_SYSEX_DATA = 3'd6;
  localparam logic [2:0] PH_MSG_DATA   = 3'd7;

  logic [2:0]         phase_r, phase_nxt;
  logic [7:0]         rs_r, rs_nxt;
  logic [LenBits-1:0] acc_r, acc_nxt;
  logic [LenBits-1:0] rem_r, rem_nxt;
  logic               esc_r, esc_nxt;

  logic [2:0]         ph;
  logic [7:0]         rs;
  logic [LenBits-1:0] acc, rem, acc_shift, rem_dec;
  logic               esc;
  logic [1:0]         sl, rl;
  logic               emit;

  // start of track clears the state seen by this byte
  assign ph  = start_of_track ? PH_DELTA : phase_r;
  assign rs  = start_of_track ? 8'h00 : rs_r;
  assign acc = start_of_track ? '0 : acc_r;
  assign rem = start_of_track ? '0 : rem_r;
  assign esc = start_of_track ? 1'b0 : esc_r;

  assign acc_shift = {acc[LenBits-8:0], data_byte[6:0] & DATA_MSK[6:0]};
  assign rem_dec   = rem - {{(LenBits-1){1'b0}}, 1'b1};
  assign sl        = msg_len(data_byte);
  assign rl        = msg_len(rs);

  // byte classification and next state
  always_comb begin
    phase_nxt = ph;
    rs_nxt    = rs;
    acc_nxt   = acc;
    rem_nxt   = rem;
    esc_nxt   = esc;
    emit      = 1'b0;
    cmd       = '0;
    unique case (ph) inside
      PH_DELTA: begin
        if (!data_byte[7]) phase_nxt = PH_STATUS;
      end
      PH_STATUS: begin
        if (data_byte == ST_META) begin
          phase_nxt = PH_META_TYPE;
        end else if (data_byte[7]) begin
          rs_nxt = data_byte;
          if (data_byte == ST_SYSEX || data_byte == ST_ESC) begin
            esc_nxt   = (data_byte == ST_ESC);
            acc_nxt   = '0;
            phase_nxt = PH_SYSEX_LEN;
          end else if (sl == 2'd0) begin
            phase_nxt = PH_DELTA;
          end else begin
            emit      = 1'b1;
            cmd.b0    = data_byte;
            cmd.e0    = (sl == 2'd1);
            rem_nxt   = LenBits'(sl - 2'd1);
            phase_nxt = (sl == 2'd1) ? PH_DELTA : PH_MSG_DATA;
          end
        end else if (rl < 2'd2) begin
          // no usable running status: byte dropped
          phase_nxt = PH_DELTA;
        end else begin
          emit      = 1'b1;
          cmd.two   = 1'b1;
          cmd.b0    = rs;
          cmd.b1    = data_byte;
          cmd.e1    = (rl == 2'd2);
          rem_nxt   = LenBits'(rl - 2'd2);
          phase_nxt = (rl == 2'd2) ? PH_DELTA : PH_MSG_DATA;
        end
      end
      PH_META_TYPE: begin
        acc_nxt   = '0;
        phase_nxt = PH_META_LEN;
      end
      PH_META_LEN, PH_SYSEX_LEN: begin
        acc_nxt = acc_shift;
        if (!data_byte[7]) begin
          rem_nxt = acc_shift;
          if (ph == PH_META_LEN) begin
            phase_nxt = (acc_shift == '0) ? PH_DELTA : PH_META_SKIP;
          end else begin
            if (!esc) begin
              emit   = 1'b1;
              cmd.b0 = ST_SYSEX;
              cmd.e0 = (acc_shift == '0);
              cmd.s0 = 1'b1;
            end
            phase_nxt = (acc_shift == '0) ? PH_DELTA : PH_SYSEX_DATA;
          end
        end
      end
      PH_META_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_DELTA;
      end
      PH_SYSEX_DATA, PH_MSG_DATA: begin
        rem_nxt = rem_dec;
        emit    = 1'b1;
        cmd.b0  = data_byte;
        cmd.e0  = (rem_dec == '0);
        cmd.s0  = (ph == PH_SYSEX_DATA);
        if (rem_dec == '0) phase_nxt = PH_DELTA;
      end
      default: phase_nxt = PH_DELTA;
    endcase
  end

  assign cmd_push = take && emit;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      rs_r    <= 8'h00;
      acc_r   <= '0;
      rem_r   <= '0;
      esc_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      esc_r   <= esc_nxt;
    end
  end

  // counting phases never sit on a zero count
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MSG_DATA || phase_r == PH_SYSEX_DATA || phase_r == PH_META_SKIP)
      |-> (rem_r != '0))
    else $error("zero byte count in a data phase");

  // a two-byte request only comes from running status
  a_two_rs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_push && cmd.two) |-> (ph == PH_STATUS && !data_byte[7]))
    else $error("two-byte request outside running status");

endmodule

// ===== hw/rtl/mtep_cmd_fifo.sv =====
module mtep_cmd_fifo
  import mtep_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mtep_cmd_t din,
  input  logic      pop,
  output mtep_cmd_t dout,
  output logic      full,
  output logic      empty
);

  mtep_cmd_t         q_r [CqDepth];
  logic [CqPtrW-1:0] wp_r, rp_r;
  logic [CqCntW-1:0] cnt_r;

  assign full  = (cnt_r == CqCntW'(CqDepth));
  assign empty = (cnt_r == '0);
  assign dout  = q_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= din;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == CqPtrW'(CqDepth - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == CqPtrW'(CqDepth - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("request queue underflow");

endmodule

// ===== hw/rtl/mtep_back.sv =====
module mtep_back
  import mtep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_empty,
  input  mtep_cmd_t  cmd,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_message_end,
  output logic       out_from_sysex,
  output logic       out_run_last
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       end_r, sx_r, last_r;
  logic       pend_r;
  logic [7:0] pb_r;
  logic       pe_r;
  logic       slot_free;

  assign slot_free = !vld_r || pop;
  assign cmd_pop   = slot_free && !pend_r && !cmd_empty;

  // output register and pending second byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else if (slot_free) begin
      if (pend_r) begin
        vld_r  <= 1'b1;
        pend_r <= 1'b0;
      end else begin
        vld_r  <= !cmd_empty;
        pend_r <= !cmd_empty && cmd.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        byte_r <= pb_r;
        end_r  <= pe_r;
        sx_r   <= 1'b0;
        last_r <= 1'b1;
      end else begin
        byte_r <= cmd.b0;
        end_r  <= cmd.e0;
        sx_r   <= cmd.s0;
        last_r <= !cmd.two;
        pb_r   <= cmd.b1;
        pe_r   <= cmd.e1;
      end
    end
  end

  assign empty           = !vld_r;
  assign out_byte        = byte_r;
  assign out_message_end = end_r;
  assign out_from_sysex  = sx_r;
  assign out_run_last    = last_r;

  // a pending second byte always sits behind a shown first byte
  a_pend_vld: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> vld_r)
    else $error("second byte pending without a first");

  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !last_r)
    else $error("first of two bytes marked last");

endmodule
